FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL; all sampled on aclk, idle in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/ldr_pkg.sv
package ldr_pkg;

    // Input byte width and result length width.
    localparam int CH_W  = 8;
    localparam int LEN_W = 9;

    // Window length saturates here.
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Number of byte codes the fold table covers.
    localparam int CH_CODES = 1 << CH_W;

    // Stream data widths, whole bytes.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    typedef logic [LEN_W-1:0] len_t;

endpackage

FILE: hdl/ldr_ram.sv
module ldr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/longest_distinct_run_length_core.sv
// Channel | Ports                     | Contents
// input   | s_tvalid/s_tready/s_tdata | tdata[7:0] ch; tuser first (starts a new string)
// result  | m_tvalid/m_tready/m_tdata | tdata[8:0] window_len, [17:9] best_len; tuser overflow
//
// One result per input byte; a byte may be taken on every cycle.
// An input transaction reaches its result through the registered read of the
// last-seen table, then the window update into the result register.
// A repeat of the previous byte's symbol is served from a bypass register.
// Synchronous active-low reset; the block then behaves as if a string began.
// A stalled result holds the update stage; input is taken once it can move.
`include "assert_macros.svh"

module longest_distinct_run_length_core #(
    parameter int POS_BITS = 16,
    parameter int ALPHABET = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ldr_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] ch
    input  logic                              s_tuser,  // [0] first
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ldr_pkg::M_TDATA_W-1:0]     m_tdata,  // [8:0] window_len, [17:9] best_len
    output logic                              m_tuser   // [0] overflow
);

    localparam int SYM_W = $clog2(ALPHABET);
    localparam int CAND_W = POS_BITS + 1;

    // Fold of every byte code onto the alphabet.
    logic [SYM_W-1:0] fold_tbl [ldr_pkg::CH_CODES];

    for (genvar i = 0; i < ldr_pkg::CH_CODES; i++) begin : g_fold
        assign fold_tbl[i] = SYM_W'(i % ALPHABET);
    end

    // Read stage.
    logic                 s1_valid_reg, s1_valid_next;
    logic [SYM_W-1:0]     s1_sym_reg;
    logic                 s1_first_reg;

    // String state.
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [POS_BITS-1:0]  ws_reg, ws_next;
    ldr_pkg::len_t        best_reg, best_next;
    logic                 ovf_reg, ovf_next;
    logic [ALPHABET-1:0]  seen_reg, seen_next;

    // Last table write, for a read issued in the same cycle.
    logic                 byp_valid_reg;
    logic [SYM_W-1:0]     byp_sym_reg;
    logic [POS_BITS-1:0]  byp_pos_reg;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    ldr_pkg::len_t        out_wlen_reg, out_best_reg;
    logic                 out_ovf_reg;

    logic                 s_accept;
    logic                 advance;
    logic [SYM_W-1:0]     sym_in;
    logic [POS_BITS-1:0]  ram_rdata;
    logic [POS_BITS-1:0]  last_pos;
    logic                 seen_hit;
    logic [POS_BITS-1:0]  pos_eff;
    logic [POS_BITS-1:0]  ws_eff;
    ldr_pkg::len_t        best_eff;
    logic                 ovf_eff;
    logic [CAND_W-1:0]    cand;
    logic [POS_BITS-1:0]  diff;
    logic [CAND_W-1:0]    wlen_full;
    ldr_pkg::len_t        wlen;

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign sym_in   = fold_tbl[s_tdata[ldr_pkg::CH_W-1:0]];

    ldr_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (ALPHABET)
    ) u_last_seen (
        .clk   (aclk),
        .we    (advance),
        .waddr (s1_sym_reg),
        .wdata (pos_eff),
        .re    (s_accept),
        .raddr (sym_in),
        .rdata (ram_rdata)
    );

    // Window update for the byte in the read stage.
    always_comb begin
        pos_eff  = s1_first_reg ? '0 : pos_reg;
        ws_eff   = s1_first_reg ? '0 : ws_reg;
        best_eff = s1_first_reg ? '0 : best_reg;
        ovf_eff  = s1_first_reg ? 1'b0 : ovf_reg;
        seen_hit = !s1_first_reg && seen_reg[s1_sym_reg];
        last_pos = (byp_valid_reg && (byp_sym_reg == s1_sym_reg)) ? byp_pos_reg : ram_rdata;
        cand     = {1'b0, last_pos} + CAND_W'(1);

        ws_next = ws_eff;
        // Move the start past the earlier occurrence, never backwards.
        if (seen_hit && (cand > {1'b0, ws_eff})) begin
            ws_next = cand[POS_BITS-1:0];
        end

        diff      = pos_eff - ws_next;
        wlen_full = {1'b0, diff} + CAND_W'(1);
        if (wlen_full > CAND_W'(ldr_pkg::LEN_MAX)) begin
            wlen = ldr_pkg::LEN_MAX;
        end else begin
            wlen = ldr_pkg::LEN_W'(wlen_full);
        end

        best_next = (wlen > best_eff) ? wlen : best_eff;
        pos_next  = pos_eff + POS_BITS'(1);
        ovf_next  = ovf_eff || (pos_next == '0);

        seen_next = s1_first_reg ? '0 : seen_reg;
        seen_next[s1_sym_reg] = 1'b1;
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
            pos_reg       <= '0;
            ws_reg        <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            seen_reg      <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                byp_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                ws_reg        <= ws_next;
                best_reg      <= best_next;
                ovf_reg       <= ovf_next;
                seen_reg      <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_sym_reg   <= sym_in;
            s1_first_reg <= s_tuser;
        end
        if (advance) begin
            byp_sym_reg  <= s1_sym_reg;
            byp_pos_reg  <= pos_eff;
            out_wlen_reg <= wlen;
            out_best_reg <= best_next;
            out_ovf_reg  <= ovf_eff;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ldr_pkg::M_TDATA_W - 2 * ldr_pkg::LEN_W){1'b0}},
                       out_best_reg, out_wlen_reg};
    assign m_tuser  = out_ovf_reg;

    `ASSERT_IMPLIES(a_wlen_le_best, out_valid_reg, out_wlen_reg <= out_best_reg, "window above best")
    `ASSERT_IMPLIES(a_wlen_nonzero, out_valid_reg, out_wlen_reg != '0, "empty window reported")
    `ASSERT_NEXT(a_first_fresh, advance && s1_first_reg, out_wlen_reg == ldr_pkg::LEN_W'(1) && out_best_reg == ldr_pkg::LEN_W'(1) && !out_ovf_reg, "new string not restarted")
    `ASSERT_NEXT(a_seen_set, advance, seen_reg[$past(s1_sym_reg)], "seen mark not set")

endmodule

FILE: tb/longest_distinct_run_length_core_tb.sv
`timescale 1ns / 1ps

module longest_distinct_run_length_core_tb;
    import ldr_pkg::*;

    localparam int POS_BITS      = 16;
    localparam int ALPHABET      = 256;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_SHOWN     = 20;
    localparam int FEED_TARGET   = 625;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef struct {
        logic [CH_W-1:0] ch;
        logic            first;
        bit              wait_drain;
    } byte_item_t;

    typedef struct {
        len_t window_len;
        len_t best_len;
        logic overflow;
    } run_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    byte_item_t  byte_feed[$];
    run_result_t expected_runs[$];
    byte_item_t  on_bus;
    int          errors = 0;
    int unsigned cycles = 0;

    // Window tracker: mirrors the block's per-string state.
    pos_t last_pos [ALPHABET];
    bit   seen     [ALPHABET];
    pos_t pos       = '0;
    pos_t win_start = '0;
    len_t best      = '0;
    bit   wrapped   = 1'b0;

    longest_distinct_run_length_core #(
        .POS_BITS(POS_BITS),
        .ALPHABET(ALPHABET)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic run_result_t next_run(input logic [CH_W-1:0] ch, input logic first);
        int unsigned     sym;
        logic [POS_BITS:0] cand;
        logic [POS_BITS:0] span;
        pos_t            diff;
        run_result_t     r;
        sym = ch % ALPHABET;
        if (first) begin
            foreach (seen[i]) seen[i] = 1'b0;
            pos       = '0;
            win_start = '0;
            best      = '0;
            wrapped   = 1'b0;
        end
        if (seen[sym]) begin
            // compare at full width so a wrap of last + 1 is not lost
            cand = {1'b0, last_pos[sym]} + 1'b1;
            if (cand > {1'b0, win_start})
                win_start = cand[POS_BITS-1:0];
        end
        last_pos[sym] = pos;
        seen[sym]     = 1'b1;
        diff = pos - win_start;
        span = {1'b0, diff} + 1'b1;
        r.window_len = (span > LEN_MAX) ? LEN_MAX : span[LEN_W-1:0];
        if (r.window_len > best)
            best = r.window_len;
        r.best_len = best;
        r.overflow = wrapped;
        pos = pos + 1'b1;
        if (pos == '0)
            wrapped = 1'b1;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int draw_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    task automatic add_byte(input logic [CH_W-1:0] ch, input logic first, input bit hold);
        byte_item_t it;
        it.ch         = ch;
        it.first      = first;
        it.wait_drain = hold;
        byte_feed.push_back(it);
    endtask

    // Bytes drawn from a window of span codes so that repeats are likely.
    task automatic add_string(input int len, input int span, input bit hold);
        logic [CH_W-1:0] base;
        logic [CH_W-1:0] ch;
        base = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            ch = base + CH_W'($urandom_range(0, span - 1));
            add_byte(ch, i == 0, hold && i == 0);
        end
    endtask

    // Every code once in shuffled order, then one repeat.
    task automatic add_all_symbols();
        logic [CH_W-1:0] order [CH_CODES];
        logic [CH_W-1:0] t;
        int              j;
        for (int i = 0; i < CH_CODES; i++)
            order[i] = CH_W'(i);
        for (int i = CH_CODES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < CH_CODES; i++)
            add_byte(order[i], i == 0, 1'b0);
        add_byte(order[$urandom_range(0, CH_CODES - 1)], 1'b0, 1'b0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            if (errors < MAX_SHOWN)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v,
                         got_v);
            errors++;
        end
    endtask

    // Driver: present queued bytes, hold a marked byte until all results are back.
    int send_gap  = 0;
    int send_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_runs.push_back(next_run(on_bus.ch, on_bus.first));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (byte_feed.size() > 0 &&
                             !(byte_feed[0].wait_drain && expected_runs.size() > 0)) begin
                    on_bus   = byte_feed.pop_front();
                    s_tdata  <= S_TDATA_W'(on_bus.ch);
                    s_tuser  <= on_bus.first;
                    s_tvalid <= 1'b1;
                    send_gap <= draw_gap(send_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    int take_gap  = 0;
    int take_calm = 0;

    always @(posedge aclk) begin : take_results
        run_result_t want;
        int          g;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_runs.size() == 0) begin
                    if (errors < MAX_SHOWN)
                        $display("%0t: unexpected result, expected none actual %h", $time,
                                 m_tdata);
                    errors++;
                end else begin
                    want = expected_runs.pop_front();
                    check_field("window_len", 32'(want.window_len), 32'(m_tdata[LEN_W-1:0]));
                    check_field("best_len", 32'(want.best_len),
                                32'(m_tdata[2*LEN_W-1:LEN_W]));
                    check_field("pad", 32'd0, 32'(m_tdata[M_TDATA_W-1:2*LEN_W]));
                    check_field("overflow", 32'(want.overflow), 32'(m_tuser));
                end
            end
            if (take_gap > 0) begin
                take_gap <= take_gap - 1;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                g = draw_gap(take_calm);
                take_gap <= (g > 0) ? g - 1 : 0;
                m_tready <= (g == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int roll;
        bit paused;
        bit hold;
        paused = 1'b0;

        // bytes before any string start
        add_byte(8'h61, 1'b0, 1'b0);
        add_byte(8'h62, 1'b0, 1'b0);
        add_byte(8'h61, 1'b0, 1'b0);
        // extremes of the byte range, repeated
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b0, 1'b0);
        // back-to-back repeat of one symbol
        add_byte(8'h55, 1'b0, 1'b0);
        add_byte(8'h55, 1'b0, 1'b0);
        // older repeat behind the window start must not pull it back
        add_byte(8'h41, 1'b1, 1'b0);
        add_byte(8'h42, 1'b0, 1'b0);
        add_byte(8'h42, 1'b0, 1'b0);
        add_byte(8'h41, 1'b0, 1'b0);
        // new strings opening on a symbol seen just before
        add_byte(8'h41, 1'b1, 1'b0);
        add_byte(8'h41, 1'b1, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'hFE, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);

        add_all_symbols();

        while (byte_feed.size() < FEED_TARGET) begin
            hold = !paused && byte_feed.size() > FEED_TARGET / 2;
            if (hold)
                paused = 1'b1;
            roll = $urandom_range(0, 9);
            if (roll == 0)
                add_byte(CH_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), hold);
            else if (roll < 6)
                add_string($urandom_range(1, 40), $urandom_range(2, 8), hold);
            else
                add_string($urandom_range(1, 40), CH_CODES, hold);
        end

        // close on a fresh string
        add_string(12, CH_CODES, 1'b0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_feed.size() > 0 || s_tvalid)
            @(negedge aclk);
        while (expected_runs.size() > 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (errors == 0 && expected_runs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/ldr_pkg.sv
hdl/ldr_ram.sv
hdl/longest_distinct_run_length_core.sv
tb/longest_distinct_run_length_core_tb.sv
